// ===== rtl/core/slt_pkg.sv =====
// slt_pkg: shared types, codes and default sizes for the sorted list table.
// Used by slt_cell and sorted_list_table_core; depends on nothing else.
package slt_pkg;

  localparam int CAPACITY_DEFAULT   = 16;
  localparam int VALUE_BITS_DEFAULT = 16;

  // request operation codes
  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_REMOVE     = 3'd1;
  localparam logic [2:0] OP_REMOVE_MIN = 3'd2;
  localparam logic [2:0] OP_REMOVE_MAX = 3'd3;
  localparam logic [2:0] OP_UPDATE     = 3'd4;

  // response status codes
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_EMPTY     = 3'd1;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
  localparam logic [2:0] STATUS_FULL      = 3'd3;
  localparam logic [2:0] STATUS_RANGE     = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] value;
    logic [3:0]  position;
  } slt_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  entry_count;
    logic [15:0] smallest;
    logic [15:0] largest;
  } slt_rsp_t;

  // what every cell of the chain does on a clock edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_GE,
    CELL_SHIFT_FROM
  } cell_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY,
    ST_INSERT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/sorted_list_table_core.sv =====
// sorted_list_table_core: sorted table built as a chain of slt_cell slots
// with a small sequencer. Depends on slt_pkg and slt_cell.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------
//  req     | in        | req_valid/req_ready  | slt_pkg::slt_req_t
//  rsp     | out       | rsp_valid/rsp_ready  | slt_pkg::slt_rsp_t
//
// A transaction passes through CMP, APPLY and DONE, and rsp_valid is set from DONE
// (update adds INSERT after APPLY, as it runs a delete pass and then an insert pass
// through the chain); a new request is taken only back in IDLE, so the table never
// works on two at once. The work lies in the compare pass, where the cell match
// flags are combined, followed by the shift pass over all cells.
// Synchronous reset empties the table at once; cells need no clearing.
// A response waiting on rsp_ready blocks a new request until it is taken.
module sorted_list_table_core #(
  parameter int CAPACITY   = slt_pkg::CAPACITY_DEFAULT,
  parameter int VALUE_BITS = slt_pkg::VALUE_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  slt_pkg::slt_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output slt_pkg::slt_rsp_t rsp
);

  localparam int STORE_BITS = (VALUE_BITS < 16) ? VALUE_BITS : 16;
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int CMP_BITS   = (CNT_BITS > 4) ? CNT_BITS : 4;

  slt_pkg::state_t     state, state_next;
  slt_pkg::slt_req_t   req_q;
  logic [2:0]          status_q, status_next;
  slt_pkg::cell_kind_t plan_kind, plan_kind_next;
  logic                plan_down, plan_down_next;
  logic                plan_reinsert, plan_reinsert_next;
  logic [CNT_BITS-1:0] cnt;

  slt_pkg::cell_kind_t cell_kind;
  logic                cnt_up, cnt_down, load_rsp;
  logic [STORE_BITS-1:0] key;
  logic [CNT_BITS-1:0]   from;

  logic [STORE_BITS-1:0] value_w [CAPACITY];
  logic [STORE_BITS-1:0] last_w  [CAPACITY];
  logic [CAPACITY-1:0]   keep_w, eq_w;

  logic                  found, full, empty;
  logic [STORE_BITS-1:0] largest_w;

  assign key   = req_q.value[STORE_BITS-1:0];
  assign full  = cnt == CNT_BITS'(CAPACITY);
  assign empty = cnt == '0;
  assign found = |eq_w;

  always_comb begin
    from = '0;
    if (req_q.operation == slt_pkg::OP_UPDATE) begin
      from = CNT_BITS'(req_q.position);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [STORE_BITS-1:0] left_value, right_value;
    logic                  left_keep;
    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_keep  = 1'b1;
    end else begin : g_mid
      assign left_value = value_w[i-1];
      assign left_keep  = keep_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_value = value_w[i];
    end else begin : g_inner
      assign right_value = value_w[i+1];
    end
    slt_cell #(
      .INDEX      (i),
      .STORE_BITS (STORE_BITS),
      .CNT_BITS   (CNT_BITS)
    ) u_cell (
      .clk         (clk),
      .kind        (cell_kind),
      .key         (key),
      .from        (from),
      .count       (cnt),
      .left_value  (left_value),
      .left_keep   (left_keep),
      .right_value (right_value),
      .value       (value_w[i]),
      .keep        (keep_w[i]),
      .eq          (eq_w[i]),
      .last_value  (last_w[i])
    );
  end

  // only the last valid cell drives a nonzero value here
  always_comb begin
    largest_w = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      largest_w = largest_w | last_w[i];
    end
  end

  // decide status and the chain action from the compare pass
  always_comb begin
    status_next        = slt_pkg::STATUS_OK;
    plan_kind_next     = slt_pkg::CELL_HOLD;
    plan_down_next     = 1'b0;
    plan_reinsert_next = 1'b0;
    case (req_q.operation)
      slt_pkg::OP_INSERT: begin
        if (full) begin
          status_next = slt_pkg::STATUS_FULL;
        end else begin
          plan_kind_next = slt_pkg::CELL_INSERT;
        end
      end
      slt_pkg::OP_REMOVE: begin
        if (empty) begin
          status_next = slt_pkg::STATUS_EMPTY;
        end else if (!found) begin
          status_next = slt_pkg::STATUS_NOT_FOUND;
        end else begin
          plan_kind_next = slt_pkg::CELL_SHIFT_GE;
          plan_down_next = 1'b1;
        end
      end
      slt_pkg::OP_REMOVE_MIN: begin
        if (empty) begin
          status_next = slt_pkg::STATUS_EMPTY;
        end else begin
          plan_kind_next = slt_pkg::CELL_SHIFT_FROM;
          plan_down_next = 1'b1;
        end
      end
      slt_pkg::OP_REMOVE_MAX: begin
        if (empty) begin
          status_next = slt_pkg::STATUS_EMPTY;
        end else begin
          plan_down_next = 1'b1;
        end
      end
      slt_pkg::OP_UPDATE: begin
        if (empty) begin
          status_next = slt_pkg::STATUS_EMPTY;
        end else if (CMP_BITS'(req_q.position) >= CMP_BITS'(cnt)) begin
          status_next = slt_pkg::STATUS_RANGE;
        end else begin
          plan_kind_next     = slt_pkg::CELL_SHIFT_FROM;
          plan_down_next     = 1'b1;
          plan_reinsert_next = 1'b1;
        end
      end
      default: status_next = slt_pkg::STATUS_OK;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      slt_pkg::ST_IDLE:   if (req_valid && req_ready) state_next = slt_pkg::ST_CMP;
      slt_pkg::ST_CMP:    state_next = slt_pkg::ST_APPLY;
      slt_pkg::ST_APPLY:  state_next = plan_reinsert ? slt_pkg::ST_INSERT : slt_pkg::ST_DONE;
      slt_pkg::ST_INSERT: state_next = slt_pkg::ST_DONE;
      slt_pkg::ST_DONE:   state_next = slt_pkg::ST_IDLE;
      default:            state_next = slt_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_ready = 1'b0;
    cell_kind = slt_pkg::CELL_HOLD;
    cnt_up    = 1'b0;
    cnt_down  = 1'b0;
    load_rsp  = 1'b0;
    unique case (state)
      slt_pkg::ST_IDLE: req_ready = !rsp_valid || rsp_ready;
      slt_pkg::ST_CMP: begin
      end
      slt_pkg::ST_APPLY: begin
        cell_kind = plan_kind;
        cnt_up    = plan_kind == slt_pkg::CELL_INSERT;
        cnt_down  = plan_down;
      end
      slt_pkg::ST_INSERT: begin
        cell_kind = slt_pkg::CELL_INSERT;
        cnt_up    = 1'b1;
      end
      slt_pkg::ST_DONE: load_rsp = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= slt_pkg::ST_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_up) begin
        cnt <= cnt + CNT_BITS'(1);
      end else if (cnt_down) begin
        cnt <= cnt - CNT_BITS'(1);
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    if (state == slt_pkg::ST_CMP) begin
      status_q      <= status_next;
      plan_kind     <= plan_kind_next;
      plan_down     <= plan_down_next;
      plan_reinsert <= plan_reinsert_next;
    end
    if (load_rsp) begin
      rsp.status      <= status_q;
      rsp.entry_count <= 5'(cnt);
      rsp.smallest    <= empty ? 16'd0 : 16'(value_w[0]);
      rsp.largest     <= 16'(largest_w);
    end
  end

  // adjacent held entries in ascending order
  logic [CAPACITY-1:0] order_ok;
  always_comb begin
    order_ok = '1;
    for (int i = 0; i + 1 < CAPACITY; i++) begin
      order_ok[i] = (CNT_BITS'(i + 1) >= cnt) || (value_w[i] <= value_w[i+1]);
    end
  end

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    state == slt_pkg::ST_IDLE |-> &order_ok)
    else $error("table entries out of order");

  a_rsp_free: assert property (@(posedge clk) disable iff (rst)
    state == slt_pkg::ST_DONE |-> !rsp_valid)
    else $error("response overwritten before it was taken");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == slt_pkg::ST_IDLE |-> cnt <= CNT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && cnt != $past(cnt) |->
      ($past(state) == slt_pkg::ST_APPLY || $past(state) == slt_pkg::ST_INSERT))
    else $error("entry count changed outside an update pass");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(rsp_valid) |-> $past(state) == slt_pkg::ST_DONE)
    else $error("response raised without a finished transaction");

endmodule

// ===== rtl/core/slt_cell.sv =====
// slt_cell: one slot of the sorted chain, holding a single entry.
// Talks to its left and right neighbors; uses slt_pkg for the command kind.
module slt_cell #(
  parameter int INDEX      = 0,
  parameter int STORE_BITS = 16,
  parameter int CNT_BITS   = 5
) (
  input  logic                    clk,
  input  slt_pkg::cell_kind_t     kind,
  input  logic [STORE_BITS-1:0]   key,
  input  logic [CNT_BITS-1:0]     from,
  input  logic [CNT_BITS-1:0]     count,
  input  logic [STORE_BITS-1:0]   left_value,
  input  logic                    left_keep,
  input  logic [STORE_BITS-1:0]   right_value,
  output logic [STORE_BITS-1:0]   value,
  output logic                    keep,
  output logic                    eq,
  output logic [STORE_BITS-1:0]   last_value
);

  localparam logic [CNT_BITS-1:0] MY_INDEX = CNT_BITS'(INDEX);
  localparam logic [CNT_BITS-1:0] MY_NEXT  = CNT_BITS'(INDEX + 1);

  logic valid;
  logic [STORE_BITS-1:0] value_next;

  assign valid      = MY_INDEX < count;
  assign keep       = valid && (value <= key);
  assign eq         = valid && (value == key);
  assign last_value = (MY_NEXT == count) ? value : '0;

  always_comb begin
    value_next = value;
    case (kind)
      slt_pkg::CELL_INSERT: begin
        // entries up to the key stay, the key lands in the first larger slot
        if (!keep) begin
          value_next = left_keep ? key : left_value;
        end
      end
      slt_pkg::CELL_SHIFT_GE: begin
        if (valid && (value >= key)) begin
          value_next = right_value;
        end
      end
      slt_pkg::CELL_SHIFT_FROM: begin
        if (MY_INDEX >= from) begin
          value_next = right_value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
